// ----- rtl/aarm_pkg.sv -----
package aarm_pkg;

  // Default field widths
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned AXIS_BITS_DEF     = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;

  // Inner fixed point: Q30
  localparam int unsigned QF = 30;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE32 = 32'd1 << QF;

  // Horner divisors and their rounded-up reciprocals (scale 2^32)
  localparam int unsigned SIN_STEPS = 6;
  localparam int unsigned COS_STEPS = 7;
  localparam logic [7:0] SIN_K [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_K [COS_STEPS] =
    '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
    32'((64'd4294967296 + 64'd155) / 64'd156),
    32'((64'd4294967296 + 64'd109) / 64'd110),
    32'((64'd4294967296 + 64'd71) / 64'd72),
    32'((64'd4294967296 + 64'd41) / 64'd42),
    32'((64'd4294967296 + 64'd19) / 64'd20),
    32'((64'd4294967296 + 64'd5) / 64'd6)
  };
  localparam logic [31:0] COS_RCP [COS_STEPS] = '{
    32'((64'd4294967296 + 64'd181) / 64'd182),
    32'((64'd4294967296 + 64'd131) / 64'd132),
    32'((64'd4294967296 + 64'd89) / 64'd90),
    32'((64'd4294967296 + 64'd55) / 64'd56),
    32'((64'd4294967296 + 64'd29) / 64'd30),
    32'((64'd4294967296 + 64'd11) / 64'd12),
    32'((64'd4294967296 + 64'd1) / 64'd2)
  };

  // Pipeline depths
  localparam int unsigned STEP_LAT    = 3;
  localparam int unsigned SC_LAT      = 2 + COS_STEPS * STEP_LAT + 1;
  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned DIV_STAGES  = 31;
  localparam int unsigned NORM_LAT    = 6 + SQRT_STAGES + DIV_STAGES;

  typedef logic signed [33:0] qv_t;
  localparam qv_t Q_ONE = 34'sd1073741824;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } nrm_tag_t;

  // Signed Q30 product, truncated toward zero
  function automatic qv_t mulq(input qv_t a, input qv_t b);
    logic [33:0] ma;
    logic [33:0] mb;
    logic [67:0] p;
    logic [33:0] pm;
    ma = a[33] ? 34'(~a + 34'sd1) : 34'(a);
    mb = b[33] ? 34'(~b + 34'sd1) : 34'(b);
    p  = ma * mb;
    pm = p[63:30];
    return (a[33] ^ b[33]) ? qv_t'(-$signed(pm)) : $signed(pm);
  endfunction

endpackage

// ----- rtl/aarm_if.sv -----
interface aarm_req_if #(
  parameter int unsigned ANGLE_BITS = aarm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned AXIS_BITS  = aarm_pkg::AXIS_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [ANGLE_BITS-1:0]       angle_turns;
  logic signed [AXIS_BITS-1:0] axis_x;
  logic signed [AXIS_BITS-1:0] axis_y;
  logic signed [AXIS_BITS-1:0] axis_z;

  modport source (output valid, angle_turns, axis_x, axis_y, axis_z, input ready);
  modport sink (input valid, angle_turns, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_rsp_if #(
  parameter int unsigned OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [OUT_FRAC_BITS+1:0] r00;
  logic signed [OUT_FRAC_BITS+1:0] r01;
  logic signed [OUT_FRAC_BITS+1:0] r02;
  logic signed [OUT_FRAC_BITS+1:0] r10;
  logic signed [OUT_FRAC_BITS+1:0] r11;
  logic signed [OUT_FRAC_BITS+1:0] r12;
  logic signed [OUT_FRAC_BITS+1:0] r20;
  logic signed [OUT_FRAC_BITS+1:0] r21;
  logic signed [OUT_FRAC_BITS+1:0] r22;
  logic                           zero_axis_flag;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  zero_axis_flag, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                zero_axis_flag, output ready);
endinterface

// ----- rtl/aarm_sincos.sv -----
module aarm_sincos #(
  parameter int unsigned ANGLE_BITS = aarm_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output aarm_pkg::qv_t         sin_o,
  output aarm_pkg::qv_t         cos_o
);
  import aarm_pkg::*;

  localparam int unsigned REM_BITS = ANGLE_BITS - 2;
  localparam int unsigned POS      = COS_STEPS * STEP_LAT;

  logic [29:0] t;
  logic [60:0] xt;
  logic [30:0] x1_q;
  logic [1:0]  quad1_q;
  logic [61:0] sq;

  logic [31:0] x2_pl_q   [POS];
  logic [30:0] x_pl_q    [POS+1];
  logic [1:0]  quad_pl_q [POS+1];

  logic [31:0]        p_q  [2][COS_STEPS];
  logic [31:0]        pc_q [2][COS_STEPS];
  logic [31:0]        q0_q [2][COS_STEPS];
  logic signed [31:0] v_q  [2][COS_STEPS];

  // Phase within the quadrant, scaled to x = t * pi/2
  assign t  = {angle_i[REM_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
  assign xt = t * HALF_PI_Q30;
  assign sq = x1_q * x1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q         <= xt[60:30];
      quad1_q      <= angle_i[ANGLE_BITS-1 -: 2];
      x2_pl_q[0]   <= sq[61:30];
      x_pl_q[0]    <= x1_q;
      quad_pl_q[0] <= quad1_q;
      for (int k = 1; k < POS; k++) x2_pl_q[k] <= x2_pl_q[k-1];
      for (int k = 1; k <= POS; k++) begin
        x_pl_q[k]    <= x_pl_q[k-1];
        quad_pl_q[k] <= quad_pl_q[k-1];
      end
    end
  end

  // Horner steps: multiply, reciprocal multiply, correct and subtract
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
      localparam logic [7:0]  KC = (l == 0) ? SIN_K[(j < SIN_STEPS) ? j : 0] : COS_K[j];
      localparam logic [31:0] RC = (l == 0) ? SIN_RCP[(j < SIN_STEPS) ? j : 0] : COS_RCP[j];
      logic [30:0] v_in;

      if (j == 0) begin : g_first
        assign v_in = ONE32[30:0];
      end else begin : g_next
        assign v_in = v_q[l][j-1][30:0];
      end

      if (l == 0 && j >= SIN_STEPS) begin : g_pass
        // sine series is shorter: hold the value to stay in step with cosine
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            p_q[l][j]  <= 32'(v_in);
            q0_q[l][j] <= p_q[l][j];
            v_q[l][j]  <= $signed(q0_q[l][j]);
          end
        end
      end else begin : g_work
        logic [62:0] pv;
        logic [63:0] pm;
        logic [39:0] qk;
        logic [31:0] qc;

        assign pv = x2_pl_q[STEP_LAT*j] * v_in;
        assign pm = p_q[l][j] * RC;
        assign qk = q0_q[l][j] * KC;
        assign qc = (qk > {8'd0, pc_q[l][j]}) ? q0_q[l][j] - 32'd1 : q0_q[l][j];

        always_ff @(posedge clk_i) begin
          if (en_i) begin
            p_q[l][j]  <= pv[61:30];
            q0_q[l][j] <= pm[63:32];
            pc_q[l][j] <= p_q[l][j];
            v_q[l][j]  <= $signed(ONE32 - qc);
          end
        end
      end
    end
  end

  logic [61:0]        sprod;
  logic [31:0]        s0;
  logic [31:0]        s0c;
  logic signed [31:0] c0;
  logic [31:0]        c0c;
  qv_t                sp;
  qv_t                cp;
  qv_t                sin_d;
  qv_t                cos_d;

  assign sprod = x_pl_q[POS] * v_q[0][COS_STEPS-1][30:0];
  assign s0    = sprod[61:30];
  assign s0c   = (s0 > ONE32) ? ONE32 : s0;
  assign c0    = v_q[1][COS_STEPS-1];
  assign c0c   = c0[31] ? 32'd0 : ((32'(c0) > ONE32) ? ONE32 : 32'(c0));
  assign sp    = qv_t'({2'b00, s0c});
  assign cp    = qv_t'({2'b00, c0c});

  // Quadrant symmetries
  always_comb begin
    case (quad_pl_q[POS])
      2'd0: begin
        sin_d = sp;
        cos_d = cp;
      end
      2'd1: begin
        sin_d = cp;
        cos_d = -sp;
      end
      2'd2: begin
        sin_d = -sp;
        cos_d = -cp;
      end
      default: begin
        sin_d = -cp;
        cos_d = sp;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

// ----- rtl/aarm_axis_norm.sv -----
module aarm_axis_norm #(
  parameter int unsigned AXIS_BITS = aarm_pkg::AXIS_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [AXIS_BITS-1:0] axis_x_i,
  input  logic signed [AXIS_BITS-1:0] axis_y_i,
  input  logic signed [AXIS_BITS-1:0] axis_z_i,
  output aarm_pkg::nrm_tag_t          tag_o,
  output logic [30:0]                 unit_x_o,
  output logic [30:0]                 unit_y_o,
  output logic [30:0]                 unit_z_o
);
  import aarm_pkg::*;

  logic signed [31:0] ext   [3];
  logic [31:0]        mag   [3];
  nrm_tag_t           tag_pl_q [NORM_LAT];

  assign ext[0] = 32'(axis_x_i);
  assign ext[1] = 32'(axis_y_i);
  assign ext[2] = 32'(axis_z_i);
  for (genvar i = 0; i < 3; i++) begin : g_abs
    assign mag[i] = ext[i][31] ? 32'(~ext[i] + 32'sd1) : 32'(ext[i]);
  end

  // Tag line: valid, zero axis and signs travel with the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NORM_LAT; k++) tag_pl_q[k] <= '0;
    end else if (en_i) begin
      tag_pl_q[0] <= '{valid: valid_i,
                       zero:  (axis_x_i == '0) && (axis_y_i == '0) && (axis_z_i == '0),
                       neg:   {axis_z_i[AXIS_BITS-1], axis_y_i[AXIS_BITS-1],
                               axis_x_i[AXIS_BITS-1]}};
      for (int k = 1; k < NORM_LAT; k++) tag_pl_q[k] <= tag_pl_q[k-1];
    end
  end
  assign tag_o = tag_pl_q[NORM_LAT-1];

  // Stage 1: magnitudes
  logic [31:0] mag1_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) mag1_q <= mag;
  end

  // Stage 2: largest magnitude, bring it below 2^30
  logic [31:0] mx;
  logic [29:0] g2_d [3];
  logic [29:0] g2_q [3];
  logic [29:0] m2_d;
  logic [29:0] m2_q;
  always_comb begin
    mx = mag1_q[0];
    if (mag1_q[1] > mx) mx = mag1_q[1];
    if (mag1_q[2] > mx) mx = mag1_q[2];
    for (int i = 0; i < 3; i++) begin
      if (mx[31]) g2_d[i] = 30'(mag1_q[i] >> 2);
      else if (mx[30]) g2_d[i] = 30'(mag1_q[i] >> 1);
      else g2_d[i] = mag1_q[i][29:0];
    end
    if (mx[31]) m2_d = 30'(mx >> 2);
    else if (mx[30]) m2_d = 30'(mx >> 1);
    else m2_d = mx[29:0];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g2_q <= g2_d;
      m2_q <= m2_d;
    end
  end

  // Stages 3 and 4: left shifts until the largest has bit 29 set
  logic [29:0] g3_d [3];
  logic [29:0] g3_q [3];
  logic [29:0] m3_d;
  logic [29:0] m3_q;
  always_comb begin
    g3_d = g2_q;
    m3_d = m2_q;
    if (m3_d[29:14] == '0) begin
      m3_d = m3_d << 16;
      for (int i = 0; i < 3; i++) g3_d[i] = g3_d[i] << 16;
    end
    if (m3_d[29:22] == '0) begin
      m3_d = m3_d << 8;
      for (int i = 0; i < 3; i++) g3_d[i] = g3_d[i] << 8;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g3_q <= g3_d;
      m3_q <= m3_d;
    end
  end

  logic [29:0] g4_d [3];
  logic [29:0] g4_q [3];
  logic [29:0] m4;
  always_comb begin
    g4_d = g3_q;
    m4   = m3_q;
    if (m4[29:26] == '0) begin
      m4 = m4 << 4;
      for (int i = 0; i < 3; i++) g4_d[i] = g4_d[i] << 4;
    end
    if (m4[29:28] == '0) begin
      m4 = m4 << 2;
      for (int i = 0; i < 3; i++) g4_d[i] = g4_d[i] << 2;
    end
    if (!m4[29]) begin
      for (int i = 0; i < 3; i++) g4_d[i] = g4_d[i] << 1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) g4_q <= g4_d;
  end

  // Stages 5 and 6: squares, then their sum
  logic [59:0] sq_q  [3];
  logic [29:0] g5_q  [3];
  logic [29:0] g6_q  [3];
  logic [61:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= g4_q[i] * g4_q[i];
      g5_q  <= g4_q;
      sum_q <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
      g6_q  <= g5_q;
    end
  end

  // Square root, one result bit per stage
  logic [62:0] sn_q  [SQRT_STAGES];
  logic [62:0] sr_q  [SQRT_STAGES];
  logic [29:0] smg_q [SQRT_STAGES][3];
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'd1 << (2 * (SQRT_STAGES - 1 - k));
    logic [62:0] n_in;
    logic [62:0] r_in;
    logic [62:0] trial;
    logic [29:0] mg_in [3];
    if (k == 0) begin : g_first
      assign n_in  = 63'(sum_q);
      assign r_in  = '0;
      assign mg_in = g6_q;
    end else begin : g_next
      assign n_in  = sn_q[k-1];
      assign r_in  = sr_q[k-1];
      assign mg_in = smg_q[k-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= trial) begin
          sn_q[k] <= n_in - trial;
          sr_q[k] <= (r_in >> 1) + BIT;
        end else begin
          sn_q[k] <= n_in;
          sr_q[k] <= r_in >> 1;
        end
        smg_q[k] <= mg_in;
      end
    end
  end

  // Restoring division of each magnitude by the length, one quotient bit per stage
  logic [60:0] dr_q [DIV_STAGES][3];
  logic [30:0] dq_q [DIV_STAGES][3];
  logic [30:0] dl_q [DIV_STAGES];
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int unsigned SHIFT = DIV_STAGES - 1 - k;
    logic [60:0] rem_in [3];
    logic [30:0] q_in   [3];
    logic [30:0] len_in;
    logic [60:0] dvs;
    if (k == 0) begin : g_first
      assign len_in = sr_q[SQRT_STAGES-1][30:0];
      for (genvar i = 0; i < 3; i++) begin : g_init
        assign rem_in[i] = {1'b0, smg_q[SQRT_STAGES-1][i], 30'd0};
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign len_in = dl_q[k-1];
      assign rem_in = dr_q[k-1];
      assign q_in   = dq_q[k-1];
    end
    assign dvs = 61'(len_in) << SHIFT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_q[k] <= len_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvs) begin
            dr_q[k][i] <= rem_in[i] - dvs;
            dq_q[k][i] <= q_in[i] | (31'd1 << SHIFT);
          end else begin
            dr_q[k][i] <= rem_in[i];
            dq_q[k][i] <= q_in[i];
          end
        end
      end
    end
  end

  assign unit_x_o = dq_q[DIV_STAGES-1][0];
  assign unit_y_o = dq_q[DIV_STAGES-1][1];
  assign unit_z_o = dq_q[DIV_STAGES-1][2];

endmodule

// ----- rtl/axis_angle_rotation_matrix.sv -----
// Axis-angle to 3x3 rotation matrix. Each request beat carries a binary angle
// (2^ANGLE_BITS is one turn) and an axis of any non-zero length; each response
// beat carries the nine elements R = c*I + (1-c)*u*u' + s*[u]x in signed
// Q1.OUT_FRAC_BITS, rounded to nearest and saturated to [-1.0, +1.0], plus a
// flag that marks an all-zero axis, for which the identity is returned. The
// block is a fully pipelined datapath: it takes one beat in every cycle that
// the output is not stalled, and returns results in order. Its depth is set
// by the axis normalisation: a square root and three dividers that each
// resolve one bit per stage (31 + 31 stages), ahead of four matrix stages;
// the sine and cosine series run alongside it.
// Ready is high whenever the output register is empty or being drained, and
// a stall freezes the whole pipeline, so no beat is lost or repeated.
module axis_angle_rotation_matrix #(
  parameter int unsigned ANGLE_BITS    = aarm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned AXIS_BITS     = aarm_pkg::AXIS_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aarm_req_if.sink   req_i,
  aarm_rsp_if.source rsp_o
);
  import aarm_pkg::*;

  localparam int unsigned ALIGN = NORM_LAT - SC_LAT;
  localparam int unsigned OUT_W = OUT_FRAC_BITS + 2;
  localparam int unsigned SH    = QF - OUT_FRAC_BITS;
  localparam logic [34:0] RND_HALF = (35'd1 << SH) >> 1;
  localparam logic [34:0] LIM35    = 35'd1 << OUT_FRAC_BITS;
  localparam logic [OUT_W-1:0] LIM = OUT_W'(1) << OUT_FRAC_BITS;

  logic en;
  logic out_valid_q;

  // Advance every stage together whenever the output register can take a beat
  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  qv_t      sin_w;
  qv_t      cos_w;
  nrm_tag_t tag;
  logic [30:0] umag [3];

  aarm_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(req_i.angle_turns),
    .sin_o  (sin_w),
    .cos_o  (cos_w)
  );

  aarm_axis_norm #(
    .AXIS_BITS(AXIS_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .axis_x_i(req_i.axis_x),
    .axis_y_i(req_i.axis_y),
    .axis_z_i(req_i.axis_z),
    .tag_o   (tag),
    .unit_x_o(umag[0]),
    .unit_y_o(umag[1]),
    .unit_z_o(umag[2])
  );

  // Hold sine and cosine back until the unit axis of the same beat is ready
  qv_t s_dly_q [ALIGN];
  qv_t c_dly_q [ALIGN];
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_dly_q[0] <= sin_w;
      c_dly_q[0] <= cos_w;
      for (int k = 1; k < ALIGN; k++) begin
        s_dly_q[k] <= s_dly_q[k-1];
        c_dly_q[k] <= c_dly_q[k-1];
      end
    end
  end

  // Signed unit components
  qv_t u [3];
  for (genvar i = 0; i < 3; i++) begin : g_unit
    assign u[i] = tag.neg[i] ? -qv_t'({3'b000, umag[i]}) : qv_t'({3'b000, umag[i]});
  end

  // Valid and zero-axis flag for the matrix stages
  logic [2:0] m_vld_q;
  logic [2:0] m_zero_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= '0;
    end else if (en) begin
      m_vld_q <= {m_vld_q[1:0], tag.valid};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) m_zero_q <= {m_zero_q[1:0], tag.zero};
  end

  // Stage M1: products of unit components, and with the sine; order of nn:
  // xx, yy, zz, xy, yz, zx
  qv_t nn_q [6];
  qv_t ns_q [3];
  qv_t omc_q;
  qv_t c1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nn_q[0] <= mulq(u[0], u[0]);
      nn_q[1] <= mulq(u[1], u[1]);
      nn_q[2] <= mulq(u[2], u[2]);
      nn_q[3] <= mulq(u[0], u[1]);
      nn_q[4] <= mulq(u[1], u[2]);
      nn_q[5] <= mulq(u[2], u[0]);
      for (int i = 0; i < 3; i++) ns_q[i] <= mulq(u[i], s_dly_q[ALIGN-1]);
      omc_q <= Q_ONE - c_dly_q[ALIGN-1];
      c1_q  <= c_dly_q[ALIGN-1];
    end
  end

  // Stage M2: scale by one minus cosine
  qv_t on_q [6];
  qv_t ns2_q [3];
  qv_t c2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) on_q[i] <= mulq(omc_q, nn_q[i]);
      ns2_q <= ns_q;
      c2_q  <= c1_q;
    end
  end

  // Stage M3: the nine elements in Q30, row-major
  qv_t r_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0] <= on_q[0] + c2_q;
      r_q[1] <= on_q[3] - ns2_q[2];
      r_q[2] <= on_q[5] + ns2_q[1];
      r_q[3] <= on_q[3] + ns2_q[2];
      r_q[4] <= on_q[1] + c2_q;
      r_q[5] <= on_q[4] - ns2_q[0];
      r_q[6] <= on_q[5] - ns2_q[1];
      r_q[7] <= on_q[4] + ns2_q[0];
      r_q[8] <= on_q[2] + c2_q;
    end
  end

  // Output stage: round half away from zero, saturate, or drop in the identity
  logic [OUT_W-1:0] elem_d [9];
  logic [OUT_W-1:0] elem_q [9];
  logic             zero_q;
  for (genvar e = 0; e < 9; e++) begin : g_out
    localparam logic [OUT_W-1:0] IDENT = (e == 0 || e == 4 || e == 8) ? LIM : '0;
    logic [33:0]      mag;
    logic [34:0]      rnd;
    logic [OUT_W-1:0] sat;
    assign mag = r_q[e][33] ? 34'(-r_q[e]) : 34'(r_q[e]);
    assign rnd = ({1'b0, mag} + RND_HALF) >> SH;
    assign sat = (rnd > LIM35) ? LIM : rnd[OUT_W-1:0];
    assign elem_d[e] = m_zero_q[2] ? IDENT : (r_q[e][33] ? OUT_W'(-sat) : sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_vld_q[2];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      elem_q <= elem_d;
      zero_q <= m_zero_q[2];
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.r00            = $signed(elem_q[0]);
  assign rsp_o.r01            = $signed(elem_q[1]);
  assign rsp_o.r02            = $signed(elem_q[2]);
  assign rsp_o.r10            = $signed(elem_q[3]);
  assign rsp_o.r11            = $signed(elem_q[4]);
  assign rsp_o.r12            = $signed(elem_q[5]);
  assign rsp_o.r20            = $signed(elem_q[6]);
  assign rsp_o.r21            = $signed(elem_q[7]);
  assign rsp_o.r22            = $signed(elem_q[8]);
  assign rsp_o.zero_axis_flag = zero_q;

  // A zero axis must come out as the identity (diagonal and r01, r12, r20 checked)
  a_zero_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && zero_q |-> elem_q[0] == LIM && elem_q[4] == LIM && elem_q[8] == LIM
      && elem_q[1] == '0 && elem_q[5] == '0 && elem_q[6] == '0)
    else $error("zero axis did not give the identity");

  // The first and last diagonal elements stay within one in magnitude
  a_diag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $signed(elem_q[0]) <= $signed(LIM) && $signed(elem_q[0]) >= -$signed(LIM)
      && $signed(elem_q[8]) <= $signed(LIM) && $signed(elem_q[8]) >= -$signed(LIM))
    else $error("diagonal element out of range");

  // A fresh result needs a live item in the last matrix stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(m_vld_q[2]))
    else $error("result appeared without a source item");

  // A stalled output freezes the matrix stages
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> $stable(m_vld_q))
    else $error("pipeline moved during a stall");

endmodule

// ----- sim/aarm_tb_if.sv -----
`timescale 1ns / 100ps

// The block's own interfaces live with the RTL; nothing further is needed here.
// This file holds a small helper package shared by the bench.
package aarm_tb_pkg;
  typedef struct packed {
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic               zero_axis_flag;
  } rot_mat_t;
endpackage

// ----- sim/axis_angle_rotation_matrix_test.sv -----
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_test;
  import aarm_tb_pkg::*;

  localparam int unsigned PIPE_LAT = 72;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aarm_req_if req_bus ();
  aarm_rsp_if rsp_bus ();

  axis_angle_rotation_matrix u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Idling percentages, changed between phases
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 73;
  int unsigned hold_off      = 0;   // cycles of forced receiver stall still to run
  int unsigned errors        = 0;
  int unsigned beats_out     = 0;
  int unsigned zero_axis_cnt = 0;

  rot_mat_t expected_mats[$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point Q30 rotation matrix, mirroring the block's arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint q_mul(longint a, longint b);
    logic             neg;
    longint unsigned  ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    p   = (ma * mb) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > (64'sd1 << 30)) return 64'sd1 << 30;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Round Q30 to Q1.14, ties away from zero, then saturate to +/-1.0
  function automatic logic signed [15:0] to_q14(longint v);
    logic            neg;
    longint unsigned mag;
    neg = v < 0;
    mag = neg ? -v : v;
    mag = (mag + (64'd1 << 15)) >> 16;
    if (mag > 16384) mag = 16384;
    return neg ? -16'(mag) : 16'(mag);
  endfunction

  function automatic rot_mat_t predict_rotation(logic [15:0] ang, logic signed [15:0] ax,
                                                logic signed [15:0] ay,
                                                logic signed [15:0] az);
    int              sk[6];
    int              ck[7];
    longint          one, x, x2, v, s0, c0, s, c, omc, xy, yz, zx;
    longint          comp[3];
    longint          unitv[3];
    longint          r[9];
    longint unsigned mg[3], m, len, t;
    rot_mat_t        res;
    one = 64'sd1 << 30;
    sk = '{156, 110, 72, 42, 20, 6};
    ck = '{182, 132, 90, 56, 30, 12, 2};
    comp[0] = ax; comp[1] = ay; comp[2] = az;
    if (ax == 0 && ay == 0 && az == 0) begin
      res = '0;
      res.r00 = 16384; res.r11 = 16384; res.r22 = 16384;
      res.zero_axis_flag = 1'b1;
      return res;
    end
    // Quarter-turn sine and cosine by Horner series
    t  = longint'(ang[13:0]) << 16;
    x  = longint'((t * 64'd1686629713) >> 30);
    x2 = q_mul(x, x);
    v  = one;
    for (int i = 0; i < 6; i++) v = one - q_mul(x2, v) / sk[i];
    s0 = clamp_unit(q_mul(x, v));
    v  = one;
    for (int i = 0; i < 7; i++) v = one - q_mul(x2, v) / ck[i];
    c0 = clamp_unit(v);
    case (ang[15:14])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
    // Normalise the axis: scale the largest magnitude into [2^29, 2^30)
    for (int i = 0; i < 3; i++) mg[i] = comp[i] < 0 ? -comp[i] : comp[i];
    m = mg[0];
    if (mg[1] > m) m = mg[1];
    if (mg[2] > m) m = mg[2];
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
      m <<= 1;
    end
    len = int_sqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
    for (int i = 0; i < 3; i++) begin
      v = longint'((mg[i] << 30) / len);
      unitv[i] = comp[i] < 0 ? -v : v;
    end
    omc = one - c;
    xy = q_mul(omc, q_mul(unitv[0], unitv[1]));
    yz = q_mul(omc, q_mul(unitv[1], unitv[2]));
    zx = q_mul(omc, q_mul(unitv[2], unitv[0]));
    r[0] = q_mul(omc, q_mul(unitv[0], unitv[0])) + c;
    r[1] = xy - q_mul(unitv[2], s);
    r[2] = zx + q_mul(unitv[1], s);
    r[3] = xy + q_mul(unitv[2], s);
    r[4] = q_mul(omc, q_mul(unitv[1], unitv[1])) + c;
    r[5] = yz - q_mul(unitv[0], s);
    r[6] = zx - q_mul(unitv[1], s);
    r[7] = yz + q_mul(unitv[0], s);
    r[8] = q_mul(omc, q_mul(unitv[2], unitv[2])) + c;
    res.r00 = to_q14(r[0]); res.r01 = to_q14(r[1]); res.r02 = to_q14(r[2]);
    res.r10 = to_q14(r[3]); res.r11 = to_q14(r[4]); res.r12 = to_q14(r[5]);
    res.r20 = to_q14(r[6]); res.r21 = to_q14(r[7]); res.r22 = to_q14(r[8]);
    res.zero_axis_flag = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one beat, hold it until accepted, then drop valid unless the
  // caller sends again straight away (valid is never lowered and re-raised in
  // one step).
  // ---------------------------------------------------------------------------
  task automatic send_rotation(logic [15:0] ang, logic signed [15:0] ax,
                               logic signed [15:0] ay, logic signed [15:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.angle_turns <= ang;
    req_bus.axis_x      <= ax;
    req_bus.axis_y      <= ay;
    req_bus.axis_z      <= az;
    expected_mats.push_back(predict_rotation(ang, ax, ay, az));
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic end_burst();
    req_bus.valid <= 1'b0;
  endtask

  // Receiver: random ready, plus a long forced hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_off != 0) begin
      rsp_bus.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: beat %0d field %s: got %0d, expected %0d", $realtime, beats_out,
             field, got, want);
    errors++;
  endtask

  // Checker: compare each accepted response beat with the oldest prediction
  always @(posedge clk_i) begin
    rot_mat_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_mats.size() == 0) begin
        $display("%0t: response beat with nothing outstanding", $realtime);
        errors++;
      end else begin
        want = expected_mats.pop_front();
        if (rsp_bus.r00 !== want.r00) report_mismatch("r00", rsp_bus.r00, want.r00);
        if (rsp_bus.r01 !== want.r01) report_mismatch("r01", rsp_bus.r01, want.r01);
        if (rsp_bus.r02 !== want.r02) report_mismatch("r02", rsp_bus.r02, want.r02);
        if (rsp_bus.r10 !== want.r10) report_mismatch("r10", rsp_bus.r10, want.r10);
        if (rsp_bus.r11 !== want.r11) report_mismatch("r11", rsp_bus.r11, want.r11);
        if (rsp_bus.r12 !== want.r12) report_mismatch("r12", rsp_bus.r12, want.r12);
        if (rsp_bus.r20 !== want.r20) report_mismatch("r20", rsp_bus.r20, want.r20);
        if (rsp_bus.r21 !== want.r21) report_mismatch("r21", rsp_bus.r21, want.r21);
        if (rsp_bus.r22 !== want.r22) report_mismatch("r22", rsp_bus.r22, want.r22);
        if (rsp_bus.zero_axis_flag !== want.zero_axis_flag)
          report_mismatch("zero_axis_flag", rsp_bus.zero_axis_flag, want.zero_axis_flag);
        if (want.zero_axis_flag) zero_axis_cnt++;
      end
      beats_out++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, each quadrant boundary, and the all-zero axis
  task automatic test_directed();
    logic signed [15:0] ext[5];
    ext = '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1, 16'sd0};
    send_rotation(16'h0000, 0, 0, 0);
    send_rotation(16'hFFFF, 0, 0, 0);
    send_rotation(16'h0000, 16'sh7FFF, 0, 0);
    send_rotation(16'h4000, 0, 16'sh7FFF, 0);
    send_rotation(16'h8000, 0, 0, 16'sh7FFF);
    send_rotation(16'hC000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_rotation(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_rotation(16'h3FFF, 1, 1, 1);
    send_rotation(16'h7FFF, -1, 0, 1);
    send_rotation(16'hBFFF, 16'sh8000, 16'sh7FFF, 0);
    send_rotation(16'h2000, 1, 0, 0);
    send_rotation(16'h1555, 0, -1, 0);
    for (int i = 0; i < 10; i++)
      send_rotation(16'($urandom), ext[$urandom_range(4)], ext[$urandom_range(4)],
                    ext[$urandom_range(4)]);
    end_burst();
  endtask

  // Random axes: mostly full range, some tiny and some with zero components
  task automatic test_random(int unsigned count);
    logic signed [15:0] c[3];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(9))
          0: c[i] = 0;
          1: c[i] = 16'($signed($urandom_range(6)) - 3);
          default: c[i] = 16'($urandom);
        endcase
      end
      if ($urandom_range(49) == 0) c = '{0, 0, 0};
      send_rotation(16'($urandom), c[0], c[1], c[2]);
    end
    end_burst();
  endtask

  // Stall the output for a long stretch so the pipeline fills and back-pressures
  task automatic test_backpressure();
    hold_off = 300;
    test_random(200);
  endtask

  task automatic wait_drain();
    while (expected_mats.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  initial begin
    req_bus.valid       <= 1'b0;
    req_bus.angle_turns <= '0;
    req_bus.axis_x      <= '0;
    req_bus.axis_y      <= '0;
    req_bus.axis_z      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(250);
    send_idle_pct = 73;
    recv_idle_pct = 27;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(280);
    wait_drain();

    $display("Covered %0d matrices (%0d with a zero axis) across all quadrants,",
             beats_out, zero_axis_cnt);
    $display("field extremes, random idling on both sides and a long output stall.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run
  initial begin
    #2ms;
    $display("Timed out with %0d beats outstanding", expected_mats.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
